FILE: sv/jesc_pkg.sv
// Shared types, constants and helpers for the Julia escape-time pixel core.
// Used by the channel interfaces, the controller, the datapath and the top level.
package jesc_pkg;

  localparam int COORD_W = 10;
  localparam int ADDR_W  = 22;
  localparam int COUNT_W = 16;
  localparam int BLUE_W  = 8;
  localparam int SHADE_W = 7;
  localparam int FIX_W   = 32;
  localparam int STEP_W  = 31;
  localparam int PROD_W  = 2 * FIX_W;
  localparam int WIDE_W  = PROD_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int HUND_W  = 10;
  localparam int DIGIT_W = 4;

  localparam int DEC_BASE     = 10;
  localparam int COLOR_SCALE  = 10;
  localparam int ESCAPE_MAG   = 4;
  localparam int BYTES_PER_PX = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd5;

  localparam logic signed [FIX_W-1:0] RST_ORIGIN_REAL = -32'sd536870912;
  localparam logic signed [FIX_W-1:0] RST_ORIGIN_IMAG = -32'sd536870912;
  localparam logic [STEP_W-1:0]       RST_PIXEL_STEP  = 31'd1048576;
  localparam logic signed [FIX_W-1:0] RST_CONST_REAL  = -32'sd195125733;
  localparam logic signed [FIX_W-1:0] RST_CONST_IMAG  = 32'sd50707458;
  localparam logic [COUNT_W-1:0]      RST_ITER_LIMIT  = 16'd256;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch column and row of an accepted request
    logic setup;     // form step * index products
    logic load;      // form the saturated start point, clear the count
    logic mul;       // register the three squares/products of z
    logic iterate;   // take one z = z^2 + c step
    logic finish;    // load the result register
  } jesc_cmd_t;

  function automatic logic signed [FIX_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-FIX_W+1){1'b0}}, {(FIX_W-1){1'b1}}};
    lo = {{(WIDE_W-FIX_W+1){1'b1}}, {(FIX_W-1){1'b0}}};
    if (v > hi) begin
      return {1'b0, {(FIX_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(FIX_W-1){1'b0}}};
    end
    return v[FIX_W-1:0];
  endfunction

endpackage

FILE: sv/jesc_pixel_if.sv
// Request channel of the Julia escape-time pixel core: one pixel's column and row.
// Depends on jesc_pkg for the field widths.
interface jesc_pixel_if;
  logic                            valid;
  logic                            ready;
  logic [jesc_pkg::COORD_W-1:0]    column;
  logic [jesc_pkg::COORD_W-1:0]    row;

  modport source (output valid, column, row, input ready);
  modport sink (input valid, column, row, output ready);
endinterface

FILE: sv/jesc_result_if.sv
// Result channel of the Julia escape-time pixel core: address, count and color.
// Depends on jesc_pkg for the field widths.
interface jesc_result_if;
  logic                            valid;
  logic                            ready;
  logic [jesc_pkg::ADDR_W-1:0]     pixel_address;
  logic [jesc_pkg::COUNT_W-1:0]    iteration_count;
  logic                            inside_res;
  logic [jesc_pkg::BLUE_W-1:0]     blue;
  logic [jesc_pkg::SHADE_W-1:0]    green;
  logic [jesc_pkg::SHADE_W-1:0]    red;

  modport source (output valid, pixel_address, iteration_count, inside_res, blue, green, red,
                  input ready);
  modport sink (input valid, pixel_address, iteration_count, inside_res, blue, green, red,
                output ready);
endinterface

FILE: sv/julia_escape_time_pixel_core.sv
// Top level of the Julia escape-time pixel core: controller plus datapath.
// Depends on jesc_pkg, jesc_pixel_if, jesc_result_if, jesc_ctrl and jesc_datapath.
//
//   Port     Dir   Kind            Carries
//   pixel    in    valid/ready     column, row
//   result   out   valid/ready     pixel_address, iteration_count, inside_res, blue, green, red
//   cfg_*    in    write only      cfg_we, cfg_index, cfg_data
//
// One pixel with n completed iterations runs from one request to the next as follows:
// each iteration is a multiply step followed by an escape test and update step, plus
// setup, start point, one final multiply and test and the result load. The limit bounds n.
// Reset is synchronous and restores the register defaults; the block is ready right after.
// The result register lets a new request start while the previous result is still waiting.
module julia_escape_time_pixel_core #(
  parameter int FRAME_WIDTH = 1024,
  parameter int FRAC_BITS   = 28
) (
  input  logic                               clk,
  input  logic                               rst,
  jesc_pixel_if.sink                         pixel,
  jesc_result_if.source                      result,
  input  logic                               cfg_we,
  input  logic [jesc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jesc_pkg::FIX_W-1:0]         cfg_data
);

  jesc_pkg::jesc_cmd_t cmd;
  logic                stop;

  jesc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel.valid),
    .pixel_ready  (pixel.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stop         (stop),
    .cmd          (cmd)
  );

  jesc_datapath #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .column          (pixel.column),
    .row             (pixel.row),
    .cmd             (cmd),
    .stop            (stop),
    .pixel_address   (result.pixel_address),
    .iteration_count (result.iteration_count),
    .inside_res      (result.inside_res),
    .blue            (result.blue),
    .green           (result.green),
    .red             (result.red)
  );

endmodule

FILE: sv/jesc_ctrl.sv
// Sequencer of the Julia escape-time pixel core: handshakes and datapath commands.
// Depends on jesc_pkg for the command struct.
module jesc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  logic                stop,
  output jesc_pkg::jesc_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SETUP,
    LOAD,
    MUL,
    CHECK,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free    = !result_valid || result_ready;
  assign pixel_ready = (state == IDLE);

  always_comb begin
    cmd         = '0;
    cmd.capture = (state == IDLE) && pixel_valid;
    cmd.setup   = (state == SETUP);
    cmd.load    = (state == LOAD);
    cmd.mul     = (state == MUL);
    cmd.iterate = (state == CHECK) && !stop;
    cmd.finish  = (state == FINISH) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE:   if (pixel_valid) state_next = SETUP;
      SETUP:  state_next = LOAD;
      LOAD:   state_next = MUL;
      MUL:    state_next = CHECK;
      CHECK:  state_next = stop ? FINISH : MUL;
      FINISH: if (out_free) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      // A new result may replace one that is taken in the same cycle.
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/jesc_datapath.sv
// Datapath of the Julia escape-time pixel core: configuration registers, start point,
// z iteration with three multipliers, decimal count digits and the result register.
// Depends on jesc_pkg for widths, register indexes and the saturation helper.
module jesc_datapath #(
  parameter int FRAME_WIDTH = 1024,
  parameter int FRAC_BITS   = 28
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [jesc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jesc_pkg::FIX_W-1:0]           cfg_data,
  input  logic [jesc_pkg::COORD_W-1:0]         column,
  input  logic [jesc_pkg::COORD_W-1:0]         row,
  input  jesc_pkg::jesc_cmd_t                  cmd,
  output logic                                 stop,
  output logic [jesc_pkg::ADDR_W-1:0]          pixel_address,
  output logic [jesc_pkg::COUNT_W-1:0]         iteration_count,
  output logic                                 inside_res,
  output logic [jesc_pkg::BLUE_W-1:0]          blue,
  output logic [jesc_pkg::SHADE_W-1:0]         green,
  output logic [jesc_pkg::SHADE_W-1:0]         red
);

  localparam int FIX_W  = jesc_pkg::FIX_W;
  localparam int WIDE_W = jesc_pkg::WIDE_W;
  localparam int PROD_W = jesc_pkg::PROD_W;
  localparam int OFS_W  = jesc_pkg::STEP_W + jesc_pkg::COORD_W;
  localparam int LIN_W  = jesc_pkg::ADDR_W + 12;
  localparam logic signed [WIDE_W-1:0] ESCAPE =
      WIDE_W'(jesc_pkg::ESCAPE_MAG) <<< FRAC_BITS;

  logic signed [FIX_W-1:0]            origin_real;
  logic signed [FIX_W-1:0]            origin_imag;
  logic [jesc_pkg::STEP_W-1:0]        pixel_step;
  logic signed [FIX_W-1:0]            const_real;
  logic signed [FIX_W-1:0]            const_imag;
  logic [jesc_pkg::COUNT_W-1:0]       iteration_limit;

  logic [jesc_pkg::COORD_W-1:0]       col_q;
  logic [jesc_pkg::COORD_W-1:0]       row_q;
  logic [OFS_W-1:0]                   ofs_real;
  logic [OFS_W-1:0]                   ofs_imag;
  logic signed [FIX_W-1:0]            zr;
  logic signed [FIX_W-1:0]            zi;
  logic signed [PROD_W-1:0]           pxx;
  logic signed [PROD_W-1:0]           pyy;
  logic signed [PROD_W-1:0]           pxy;
  logic [jesc_pkg::COUNT_W-1:0]       count;
  logic [jesc_pkg::DIGIT_W-1:0]       ones;
  logic [jesc_pkg::DIGIT_W-1:0]       tens;
  logic [jesc_pkg::HUND_W-1:0]        hund;

  logic signed [WIDE_W-1:0]           xx;
  logic signed [WIDE_W-1:0]           yy;
  logic signed [WIDE_W-1:0]           xy2;
  logic signed [WIDE_W-1:0]           start_real;
  logic signed [WIDE_W-1:0]           start_imag;
  logic [LIN_W-1:0]                   lin;
  logic [jesc_pkg::HUND_W+3:0]        blue_full;
  logic                               limit_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real     <= jesc_pkg::RST_ORIGIN_REAL;
      origin_imag     <= jesc_pkg::RST_ORIGIN_IMAG;
      pixel_step      <= jesc_pkg::RST_PIXEL_STEP;
      const_real      <= jesc_pkg::RST_CONST_REAL;
      const_imag      <= jesc_pkg::RST_CONST_IMAG;
      iteration_limit <= jesc_pkg::RST_ITER_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jesc_pkg::REG_ORIGIN_REAL: origin_real <= cfg_data;
        jesc_pkg::REG_ORIGIN_IMAG: origin_imag <= cfg_data;
        jesc_pkg::REG_PIXEL_STEP:  pixel_step <= cfg_data[jesc_pkg::STEP_W-1:0];
        jesc_pkg::REG_CONST_REAL:  const_real <= cfg_data;
        jesc_pkg::REG_CONST_IMAG:  const_imag <= cfg_data;
        jesc_pkg::REG_ITER_LIMIT:  iteration_limit <= cfg_data[jesc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Shifted products are floor-rounded by the arithmetic shift.
  assign xx  = WIDE_W'(pxx >>> FRAC_BITS);
  assign yy  = WIDE_W'(pyy >>> FRAC_BITS);
  assign xy2 = WIDE_W'(pxy >>> (FRAC_BITS - 1));
  assign stop = ((xx + yy) >= ESCAPE) || (count >= iteration_limit);

  assign start_real = WIDE_W'(origin_real) + $signed(WIDE_W'(ofs_real));
  assign start_imag = WIDE_W'(origin_imag) + $signed(WIDE_W'(ofs_imag));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_q <= column;
      row_q <= row;
    end
    if (cmd.setup) begin
      ofs_real <= OFS_W'(pixel_step) * OFS_W'(col_q);
      ofs_imag <= OFS_W'(pixel_step) * OFS_W'(row_q);
    end
    if (cmd.mul) begin
      pxx <= zr * zr;
      pyy <= zi * zi;
      pxy <= zr * zi;
    end
    if (cmd.load) begin
      zr    <= jesc_pkg::sat32(start_real);
      zi    <= jesc_pkg::sat32(start_imag);
      count <= '0;
      ones  <= '0;
      tens  <= '0;
      hund  <= '0;
    end else if (cmd.iterate) begin
      zr    <= jesc_pkg::sat32(xx - yy + WIDE_W'(const_real));
      zi    <= jesc_pkg::sat32(xy2 + WIDE_W'(const_imag));
      count <= count + 1'b1;
      // Decimal digits of the count follow it, so no divider is needed for the color.
      if (ones == jesc_pkg::DIGIT_W'(jesc_pkg::DEC_BASE - 1)) begin
        ones <= '0;
        if (tens == jesc_pkg::DIGIT_W'(jesc_pkg::DEC_BASE - 1)) begin
          tens <= '0;
          hund <= hund + 1'b1;
        end else begin
          tens <= tens + 1'b1;
        end
      end else begin
        ones <= ones + 1'b1;
      end
    end
  end

  assign lin       = LIN_W'(row_q) * LIN_W'(FRAME_WIDTH) + LIN_W'(col_q);
  assign blue_full = (jesc_pkg::HUND_W+4)'(hund) * (jesc_pkg::HUND_W+4)'(jesc_pkg::COLOR_SCALE);
  assign limit_hit = (count == iteration_limit);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pixel_address   <= jesc_pkg::ADDR_W'(lin * LIN_W'(jesc_pkg::BYTES_PER_PX));
      iteration_count <= count;
      inside_res      <= limit_hit;
      if (limit_hit) begin
        blue  <= '0;
        green <= '0;
        red   <= '0;
      end else begin
        blue  <= blue_full[jesc_pkg::BLUE_W-1:0];
        green <= jesc_pkg::SHADE_W'(tens) * jesc_pkg::SHADE_W'(jesc_pkg::COLOR_SCALE);
        red   <= jesc_pkg::SHADE_W'(ones) * jesc_pkg::SHADE_W'(jesc_pkg::COLOR_SCALE);
      end
    end
  end

endmodule

FILE: sv/jesc_checker.sv
// Port-level checks for the Julia escape-time pixel core, attached by bind.
// Depends on jesc_pkg for field widths and on the top level's interface ports.
module jesc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            pixel_valid,
  input logic                            pixel_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [jesc_pkg::ADDR_W-1:0]     pixel_address,
  input logic [jesc_pkg::COUNT_W-1:0]    iteration_count,
  input logic                            inside_res,
  input logic [jesc_pkg::BLUE_W-1:0]     blue,
  input logic [jesc_pkg::SHADE_W-1:0]    green,
  input logic [jesc_pkg::SHADE_W-1:0]    red
);

  // No result may be offered right after reset.
  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered right after reset");

  // A stalled result holds all of its fields.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
      result_valid && !result_ready |=>
        result_valid && $stable(pixel_address) && $stable(iteration_count) &&
        $stable(inside_res) && $stable(blue) && $stable(green) && $stable(red))
    else $error("stalled result changed");

  // Inside pixels are black.
  a_inside_black: assert property (@(posedge clk) disable iff (rst)
      result_valid && inside_res |-> blue == '0 && green == '0 && red == '0)
    else $error("inside pixel is not black");

  // One request at a time: the core is busy in the cycle after taking one.
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
      pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("second request taken while busy");

  // Shade digits never exceed nine times the scale.
  a_shade_range: assert property (@(posedge clk) disable iff (rst)
      result_valid |-> green <= jesc_pkg::SHADE_W'(9 * jesc_pkg::COLOR_SCALE) &&
                       red <= jesc_pkg::SHADE_W'(9 * jesc_pkg::COLOR_SCALE))
    else $error("shade value out of range");

endmodule

bind julia_escape_time_pixel_core jesc_checker u_jesc_checker (
  .clk             (clk),
  .rst             (rst),
  .pixel_valid     (pixel.valid),
  .pixel_ready     (pixel.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .pixel_address   (result.pixel_address),
  .iteration_count (result.iteration_count),
  .inside_res      (result.inside_res),
  .blue            (result.blue),
  .green           (result.green),
  .red             (result.red)
);

FILE: tb/escape_time_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Julia escape-time pixel core: follows the configuration port,
// predicts every accepted pixel request and compares it with the result channel.
// Depends on jesc_pkg, jesc_pixel_if and jesc_result_if.
module escape_time_checker #(
  parameter int FRAME_WIDTH = 1024,
  parameter int FRAC_BITS   = 28
) (
  input  logic                           clk,
  input  logic                           rst,
  jesc_pixel_if                          pixel,
  jesc_result_if                         result,
  input  logic                           cfg_we,
  input  logic [jesc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jesc_pkg::FIX_W-1:0]     cfg_data,
  output int unsigned                    error_count,
  output int unsigned                    pending_results
);

  typedef struct packed {
    logic [jesc_pkg::ADDR_W-1:0]  addr;
    logic [jesc_pkg::COUNT_W-1:0] count;
    logic                         in_set;
    logic [jesc_pkg::BLUE_W-1:0]  blue;
    logic [jesc_pkg::SHADE_W-1:0] green;
    logic [jesc_pkg::SHADE_W-1:0] red;
  } pixel_result_t;

  localparam longint FIX_MAX = 64'sd2147483647;
  localparam longint FIX_MIN = -64'sd2147483648;

  logic signed [jesc_pkg::FIX_W-1:0] origin_re;
  logic signed [jesc_pkg::FIX_W-1:0] origin_im;
  logic [jesc_pkg::STEP_W-1:0]       pitch;
  logic signed [jesc_pkg::FIX_W-1:0] c_re;
  logic signed [jesc_pkg::FIX_W-1:0] c_im;
  logic [jesc_pkg::COUNT_W-1:0]      iter_cap;

  pixel_result_t expected_q[$];
  int unsigned   errors = 0;

  assign error_count = errors;

  function automatic longint clamp_fix(input longint v);
    if (v > FIX_MAX) begin
      return FIX_MAX;
    end else if (v < FIX_MIN) begin
      return FIX_MIN;
    end
    return v;
  endfunction

  // The arithmetic shifts of longint values round toward minus infinity, as the block does.
  function automatic pixel_result_t escape_pixel(input logic [jesc_pkg::COORD_W-1:0] col,
                                                 input logic [jesc_pkg::COORD_W-1:0] row);
    longint        zr;
    longint        zi;
    longint        xx;
    longint        yy;
    longint        xy2;
    longint        bound;
    int unsigned   n;
    pixel_result_t r;
    bound = longint'(jesc_pkg::ESCAPE_MAG) <<< FRAC_BITS;
    zr = clamp_fix(longint'(origin_re) + longint'(pitch) * longint'(col));
    zi = clamp_fix(longint'(origin_im) + longint'(pitch) * longint'(row));
    n = 0;
    while (1'b1) begin
      xx = (zr * zr) >>> FRAC_BITS;
      yy = (zi * zi) >>> FRAC_BITS;
      if (xx + yy >= bound || n >= iter_cap) break;
      xy2 = (zr * zi) >>> (FRAC_BITS - 1);
      zi = clamp_fix(xy2 + longint'(c_im));
      zr = clamp_fix(xx - yy + longint'(c_re));
      n++;
    end
    r.addr   = jesc_pkg::ADDR_W'((longint'(row) * FRAME_WIDTH + longint'(col)) *
                                 jesc_pkg::BYTES_PER_PX);
    r.count  = jesc_pkg::COUNT_W'(n);
    r.in_set = (n == iter_cap);
    if (r.in_set) begin
      r.blue  = '0;
      r.green = '0;
      r.red   = '0;
    end else begin
      r.blue  = jesc_pkg::BLUE_W'((n / (jesc_pkg::DEC_BASE * jesc_pkg::DEC_BASE)) *
                                  jesc_pkg::COLOR_SCALE);
      r.green = jesc_pkg::SHADE_W'(((n / jesc_pkg::DEC_BASE) % jesc_pkg::DEC_BASE) *
                                   jesc_pkg::COLOR_SCALE);
      r.red   = jesc_pkg::SHADE_W'((n % jesc_pkg::DEC_BASE) * jesc_pkg::COLOR_SCALE);
    end
    return r;
  endfunction

  function automatic string show(input pixel_result_t r);
    return $sformatf("addr=%0d count=%0d in_set=%0b b/g/r=%0d/%0d/%0d",
                     r.addr, r.count, r.in_set, r.blue, r.green, r.red);
  endfunction

  always @(posedge clk) begin
    pixel_result_t got;
    pixel_result_t want;
    if (rst) begin
      origin_re = jesc_pkg::RST_ORIGIN_REAL;
      origin_im = jesc_pkg::RST_ORIGIN_IMAG;
      pitch     = jesc_pkg::RST_PIXEL_STEP;
      c_re      = jesc_pkg::RST_CONST_REAL;
      c_im      = jesc_pkg::RST_CONST_IMAG;
      iter_cap  = jesc_pkg::RST_ITER_LIMIT;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          jesc_pkg::REG_ORIGIN_REAL: origin_re = cfg_data;
          jesc_pkg::REG_ORIGIN_IMAG: origin_im = cfg_data;
          jesc_pkg::REG_PIXEL_STEP:  pitch     = cfg_data[jesc_pkg::STEP_W-1:0];
          jesc_pkg::REG_CONST_REAL:  c_re      = cfg_data;
          jesc_pkg::REG_CONST_IMAG:  c_im      = cfg_data;
          jesc_pkg::REG_ITER_LIMIT:  iter_cap  = cfg_data[jesc_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      // Results are retired before new requests are queued, so a result can never
      // be matched against the request accepted on the same edge.
      if (result.valid && result.ready) begin
        got.addr   = result.pixel_address;
        got.count  = result.iteration_count;
        got.in_set = result.inside_res;
        got.blue   = result.blue;
        got.green  = result.green;
        got.red    = result.red;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %s, got %s", show(want), show(got));
          end
        end
      end
      if (pixel.valid && pixel.ready) expected_q.push_back(escape_pixel(pixel.column, pixel.row));
    end
    pending_results <= expected_q.size();
  end

endmodule

FILE: tb/julia_escape_time_pixel_core_test.sv
`timescale 1ns / 100ps
// Top of the Julia escape-time pixel core testbench: clock, reset, pixel requests,
// configuration writes and result back-pressure. Depends on jesc_pkg, the two
// channel interfaces, julia_escape_time_pixel_core and escape_time_checker.
module julia_escape_time_pixel_core_test;

  localparam int FRAME_WIDTH   = 1024;
  localparam int FRAC_BITS     = 28;
  localparam int ONE           = 1 << FRAC_BITS;
  localparam int IDLE_PCT      = 28;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT   = 2500000;
  localparam int COORD_MAX     = (1 << jesc_pkg::COORD_W) - 1;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [jesc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [jesc_pkg::FIX_W-1:0]     cfg_data;
  int unsigned                    error_count;
  int unsigned                    pending_results;
  int unsigned                    cycle_count = 0;
  bit                             tx_steady = 1'b0;
  bit                             rx_steady = 1'b0;
  bit                             hold_req = 1'b0;

  jesc_pixel_if  pixel_ch ();
  jesc_result_if result_ch ();

  julia_escape_time_pixel_core #(
    .FRAME_WIDTH(FRAME_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  escape_time_checker #(
    .FRAME_WIDTH(FRAME_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) orbit_check (
    .clk            (clk),
    .rst            (rst),
    .pixel          (pixel_ch),
    .result         (result_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .pending_results(pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Result side: random back-pressure (always ready in steady mode), plus one long hold-off once it is requested.
  initial begin
    int held;
    held = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        result_ch.ready <= 1'b0;
        held++;
      end else begin
        result_ch.ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // The stimulus tasks are entered and left right after a rising edge.
  task automatic write_reg(input logic [jesc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jesc_pkg::FIX_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_view(input logic [jesc_pkg::FIX_W-1:0] org_re,
                           input logic [jesc_pkg::FIX_W-1:0] org_im,
                           input logic [jesc_pkg::FIX_W-1:0] pitch,
                           input logic [jesc_pkg::FIX_W-1:0] c_re,
                           input logic [jesc_pkg::FIX_W-1:0] c_im,
                           input logic [jesc_pkg::FIX_W-1:0] iter_cap);
    write_reg(jesc_pkg::REG_ORIGIN_REAL, org_re);
    write_reg(jesc_pkg::REG_ORIGIN_IMAG, org_im);
    write_reg(jesc_pkg::REG_PIXEL_STEP, pitch);
    write_reg(jesc_pkg::REG_CONST_REAL, c_re);
    write_reg(jesc_pkg::REG_CONST_IMAG, c_im);
    write_reg(jesc_pkg::REG_ITER_LIMIT, iter_cap);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(input int col, input int row);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid  <= 1'b1;
    pixel_ch.column <= jesc_pkg::COORD_W'(col);
    pixel_ch.row    <= jesc_pkg::COORD_W'(row);
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
  endtask

  // The extra edge lets the checker count the request accepted last.
  task automatic drain_results();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    end
  endtask

  initial begin
    int kind;
    int pitch;
    int org_re;
    int org_im;
    int c_re;
    int c_im;
    int iter_cap;
    int pick;
    int classic_re[4];
    int classic_im[4];
    classic_re = '{-107374182, 76504105, -214748365, -195125733};
    classic_im = '{161061274, 2684355, 41875931, 50707458};
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= jesc_pkg::REG_ORIGIN_REAL;
    cfg_data        <= '0;
    pixel_ch.valid  <= 1'b0;
    pixel_ch.column <= '0;
    pixel_ch.row    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Power-on view: frame corners, the center (stays bounded) and alternating bits.
    send_pixel(0, 0);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel(0, COORD_MAX);
    send_pixel(COORD_MAX, 0);
    send_pixel(512, 512);
    send_pixel('h2AA, 'h155);
    send_pixel('h155, 'h2AA);
    drain_results();

    // With a zero limit every pixel is black, even one far outside the set.
    load_view(jesc_pkg::RST_ORIGIN_REAL, jesc_pkg::RST_ORIGIN_IMAG,
              jesc_pkg::FIX_W'(jesc_pkg::RST_PIXEL_STEP), jesc_pkg::RST_CONST_REAL,
              jesc_pkg::RST_CONST_IMAG, 0);
    send_pixel(512, 512);
    send_pixel(0, 0);
    drain_results();

    // The first iterate overflows: the real part clips high here, low in the next view.
    load_view(32'sd510027366, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h0000FFFF);
    send_pixel(0, 0);
    send_pixel(COORD_MAX, COORD_MAX);
    drain_results();
    load_view(0, 32'sd510027366, 0, 32'h80000000, 32'h7FFFFFFF, 32'h0000FFFF);
    send_pixel(5, 5);
    drain_results();

    // The start point itself clips at the high end of the range and sits on both ends at (0, 0).
    load_view(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 32'h0000FFFF);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel(0, 0);
    send_pixel(0, 1);
    drain_results();

    // A fixed point at zero runs the full limit.
    load_view(0, 0, 0, 0, 0, 32'h0000FFFF);
    send_pixel(0, 0);
    drain_results();

    for (int ph = 0; ph < 14; ph++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // Arbitrary register contents; the upper limit bits are don't-care.
        load_view($urandom, $urandom, $urandom, $urandom, $urandom,
                  ($urandom & 32'hFFFF0000) | $urandom_range(0, 40));
      end else begin
        pitch  = $urandom_range(ONE >> 9, ONE >> 7);
        org_re = -(pitch * 512) + int'($urandom_range(0, ONE / 2)) - ONE / 4;
        org_im = -(pitch * 512) + int'($urandom_range(0, ONE / 2)) - ONE / 4;
        if (kind <= 4) begin
          pick = $urandom_range(0, 3);
          c_re = classic_re[pick];
          c_im = classic_im[pick];
        end else begin
          c_re = int'($urandom_range(0, 2 * ONE)) - ONE;
          c_im = int'($urandom_range(0, 2 * ONE)) - ONE;
        end
        iter_cap = (kind == 1) ? 0 : $urandom_range(1, 64);
        load_view(org_re, org_im, pitch, c_re, c_im, iter_cap);
      end
      if (ph == 3) hold_req <= 1'b1;
      if (ph == 5) begin
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
      end
      if (ph == 6) begin
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
      end
      for (int i = 0; i < 100; i++) begin
        if (ph == 8 && i == 50) drain_results();
        send_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end
      drain_results();
    end

    load_view(jesc_pkg::RST_ORIGIN_REAL, jesc_pkg::RST_ORIGIN_IMAG,
              jesc_pkg::FIX_W'(jesc_pkg::RST_PIXEL_STEP), jesc_pkg::RST_CONST_REAL,
              jesc_pkg::RST_CONST_IMAG, jesc_pkg::FIX_W'(jesc_pkg::RST_ITER_LIMIT));
    send_random(150);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/jesc_pkg.sv
sv/jesc_pixel_if.sv
sv/jesc_result_if.sv
sv/jesc_ctrl.sv
sv/jesc_datapath.sv
sv/julia_escape_time_pixel_core.sv
sv/jesc_checker.sv
tb/escape_time_checker.sv
tb/julia_escape_time_pixel_core_test.sv
